// ===== rtl/core/dfs_pf_pkg.sv =====
// Shared types, microcode step names and the control store of the path finder.
package dfs_pf_pkg;

  typedef logic [4:0] step_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_INIT,
    ACT_READ_TOP,
    ACT_READ_ROW,
    ACT_SCAN,
    ACT_PUSH,
    ACT_PUSH2,
    ACT_POP,
    ACT_TRACE_INIT,
    ACT_TRACE,
    ACT_TRACE_NEXT,
    ACT_TRACE_END,
    ACT_EREAD,
    ACT_EOUT,
    ACT_OUT_ONE
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_SEARCH,
    C_TRIVIAL,
    C_EMPTY,
    C_MISS,
    C_EXHAUSTED,
    C_END_UNVISITED,
    C_AT_START,
    C_OUT_BUSY,
    C_K_VALID
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctl_t;

  localparam step_t S_IDLE       = 5'd0;
  localparam step_t S_CHECK      = 5'd1;
  localparam step_t S_INIT       = 5'd2;
  localparam step_t S_TOP        = 5'd3;
  localparam step_t S_ROW        = 5'd4;
  localparam step_t S_SCAN       = 5'd5;
  localparam step_t S_SPLIT      = 5'd6;
  localparam step_t S_PUSH       = 5'd7;
  localparam step_t S_PUSH2      = 5'd8;
  localparam step_t S_POP        = 5'd9;
  localparam step_t S_VISCHK     = 5'd10;
  localparam step_t S_TRACE      = 5'd11;
  localparam step_t S_TRACE_NEXT = 5'd12;
  localparam step_t S_TRACE_END  = 5'd13;
  localparam step_t S_EREAD      = 5'd14;
  localparam step_t S_EOUT       = 5'd15;
  localparam step_t S_ELOOP      = 5'd16;
  localparam step_t S_RET        = 5'd17;
  localparam step_t S_EMIT_ONE   = 5'd18;
  localparam step_t S_RET2       = 5'd19;

  function automatic ctl_t ucode(input step_t pc);
    ctl_t w;
    case (pc)
      S_IDLE:       w = '{ACT_ACCEPT,     C_NO_SEARCH,     S_IDLE};
      S_CHECK:      w = '{ACT_NONE,       C_TRIVIAL,       S_EMIT_ONE};
      S_INIT:       w = '{ACT_INIT,       C_NEVER,         S_IDLE};
      S_TOP:        w = '{ACT_READ_TOP,   C_EMPTY,         S_VISCHK};
      S_ROW:        w = '{ACT_READ_ROW,   C_NEVER,         S_IDLE};
      S_SCAN:       w = '{ACT_SCAN,       C_MISS,          S_SCAN};
      S_SPLIT:      w = '{ACT_NONE,       C_EXHAUSTED,     S_POP};
      S_PUSH:       w = '{ACT_PUSH,       C_NEVER,         S_IDLE};
      S_PUSH2:      w = '{ACT_PUSH2,      C_ALWAYS,        S_TOP};
      S_POP:        w = '{ACT_POP,        C_ALWAYS,        S_TOP};
      S_VISCHK:     w = '{ACT_TRACE_INIT, C_END_UNVISITED, S_EMIT_ONE};
      S_TRACE:      w = '{ACT_TRACE,      C_AT_START,      S_TRACE_END};
      S_TRACE_NEXT: w = '{ACT_TRACE_NEXT, C_ALWAYS,        S_TRACE};
      S_TRACE_END:  w = '{ACT_TRACE_END,  C_NEVER,         S_IDLE};
      S_EREAD:      w = '{ACT_EREAD,      C_NEVER,         S_IDLE};
      S_EOUT:       w = '{ACT_EOUT,       C_OUT_BUSY,      S_EOUT};
      S_ELOOP:      w = '{ACT_NONE,       C_K_VALID,       S_EREAD};
      S_RET:        w = '{ACT_NONE,       C_ALWAYS,        S_IDLE};
      S_EMIT_ONE:   w = '{ACT_OUT_ONE,    C_OUT_BUSY,      S_EMIT_ONE};
      S_RET2:       w = '{ACT_NONE,       C_ALWAYS,        S_IDLE};
      default:      w = '{ACT_NONE,       C_ALWAYS,        S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/dfs_path_finder_core.sv =====
// Depth-first path finder: microcoded sequencer, graph and stack memories, output register.
//
// A request with tuser low loads one adjacency row; rows at or above
// VERTICES are dropped. A request with tuser high runs a depth-first
// search from start_vertex and streams the path to end_vertex, start
// first, with tlast on the final vertex; an unreachable end, or an
// out-of-range start or end, gives a single result with tuser (no_path)
// set. A search reads adjacency rows through the single read port and
// scans their neighbours, then checks reachability, traces the path
// back over the parent memory into the path buffer and emits it from
// there, each emitted vertex waiting while the output register is full.
// Requests are taken only while the sequencer sits in its idle step; a
// waiting result in the output register does not block loads.
module dfs_path_finder_core #(
  parameter int VERTICES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // row[3:0], edges[19:4], start_vertex[23:20], end_vertex[27:24]
  input  logic        s_tuser,   // op[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // vertex[3:0]
  output logic        m_tlast,
  output logic        m_tuser    // no_path[0]
);
  import dfs_pf_pkg::*;

  localparam int VW = $clog2(VERTICES);
  localparam int VP = 1 << VW;
  localparam int CW = VW + 1;
  localparam logic [CW-1:0] VCNT = CW'(VERTICES);

  logic [VP-1:0] adj_mem [0:VERTICES-1];
  logic [VW-1:0] par_mem [0:VERTICES-1];
  logic [VW-1:0] sv_mem  [0:VERTICES-1];
  logic [CW-1:0] sn_mem  [0:VERTICES-1];
  logic [VW-1:0] pb_mem  [0:VERTICES-1];

  step_t         pc;
  ctl_t          ctl;
  logic          take;
  logic          out_free;

  logic [VP-1:0] visited;
  logic [CW-1:0] depth;
  logic [CW-1:0] top_idx;
  logic [VP-1:0] row_q;
  logic [VW-1:0] par_q;
  logic [VW-1:0] sv_q;
  logic [CW-1:0] sn_q;
  logic [VW-1:0] pb_q;
  logic [VW-1:0] cur_v;
  logic [CW-1:0] j;
  logic [VW-1:0] count;
  logic [CW-1:0] k;
  logic [VW-1:0] start_v;
  logic [VW-1:0] end_v;
  logic [3:0]    start_raw;
  logic          bad_q;

  logic [3:0]    out_vertex;
  logic          out_last;
  logic          out_nopath;

  logic          hit;
  logic          exhausted;
  logic          accept;

  assign ctl       = ucode(pc);
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (ctl.act == ACT_ACCEPT);
  assign accept    = s_tvalid && s_tready;
  assign top_idx   = depth - 1'b1;
  assign exhausted = (j >= VCNT);
  assign hit       = !exhausted && row_q[j[VW-1:0]] && !visited[j[VW-1:0]];

  assign m_tdata   = {4'd0, out_vertex};
  assign m_tlast   = out_last;
  assign m_tuser   = out_nopath;

  always_comb begin
    case (ctl.cond)
      C_NEVER:         take = 1'b0;
      C_ALWAYS:        take = 1'b1;
      C_NO_SEARCH:     take = !(s_tvalid && s_tuser);
      C_TRIVIAL:       take = bad_q || (start_v == end_v);
      C_EMPTY:         take = (depth == '0);
      C_MISS:          take = !hit && !exhausted;
      C_EXHAUSTED:     take = exhausted;
      C_END_UNVISITED: take = !visited[end_v];
      C_AT_START:      take = (cur_v == start_v);
      C_OUT_BUSY:      take = !out_free;
      C_K_VALID:       take = !k[VW];
      default:         take = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= S_IDLE;
      depth    <= '0;
      visited  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      pc <= take ? ctl.target : pc + 1'b1;
      if (((ctl.act == ACT_EOUT) || (ctl.act == ACT_OUT_ONE)) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (ctl.act)
        ACT_INIT: begin
          visited <= VP'(1) << start_v;
          depth   <= CW'(1);
        end
        ACT_PUSH: begin
          visited[j[VW-1:0]] <= 1'b1;
        end
        ACT_PUSH2: begin
          depth <= depth + 1'b1;
        end
        ACT_POP: begin
          depth <= top_idx;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers and memories
  always_ff @(posedge clk) begin
    case (ctl.act)
      ACT_ACCEPT: begin
        if (accept) begin
          if (!s_tuser && (int'(s_tdata[3:0]) < VERTICES)) begin
            adj_mem[VW'(s_tdata[3:0])] <= VP'(s_tdata[19:4]);
          end
          start_raw <= s_tdata[23:20];
          start_v   <= VW'(s_tdata[23:20]);
          end_v     <= VW'(s_tdata[27:24]);
          bad_q     <= (int'(s_tdata[23:20]) >= VERTICES) ||
                       (int'(s_tdata[27:24]) >= VERTICES);
        end
      end
      ACT_INIT: begin
        par_mem[start_v] <= start_v;
        sv_mem[0]        <= start_v;
        sn_mem[0]        <= '0;
      end
      ACT_READ_TOP: begin
        sv_q <= sv_mem[top_idx[VW-1:0]];
        sn_q <= sn_mem[top_idx[VW-1:0]];
      end
      ACT_READ_ROW: begin
        row_q <= adj_mem[sv_q];
        cur_v <= sv_q;
        j     <= sn_q;
      end
      ACT_SCAN: begin
        if (!hit && !exhausted) begin
          j <= j + 1'b1;
        end
      end
      ACT_PUSH: begin
        sn_mem[top_idx[VW-1:0]] <= j + 1'b1;
        par_mem[j[VW-1:0]]      <= cur_v;
        sv_mem[depth[VW-1:0]]   <= j[VW-1:0];
      end
      ACT_PUSH2: begin
        sn_mem[depth[VW-1:0]] <= '0;
      end
      ACT_TRACE_INIT: begin
        count <= '0;
        cur_v <= end_v;
      end
      ACT_TRACE: begin
        if (cur_v != start_v) begin
          pb_mem[count] <= cur_v;
          count         <= count + 1'b1;
          par_q         <= par_mem[cur_v];
        end
      end
      ACT_TRACE_NEXT: begin
        cur_v <= par_q;
      end
      ACT_TRACE_END: begin
        pb_mem[count] <= start_v;
        k             <= {1'b0, count};
      end
      ACT_EREAD: begin
        pb_q <= pb_mem[k[VW-1:0]];
      end
      ACT_EOUT: begin
        if (out_free) begin
          out_vertex <= 4'(pb_q);
          out_last   <= (k[VW-1:0] == '0);
          out_nopath <= 1'b0;
          k          <= k - 1'b1;
        end
      end
      ACT_OUT_ONE: begin
        if (out_free) begin
          out_vertex <= (bad_q || (start_v != end_v)) ? 4'd0 : start_raw;
          out_last   <= 1'b1;
          out_nopath <= bad_q || (start_v != end_v);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/sv/tb_dfs_path_finder_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for dfs_path_finder_core: graph loads and path searches.
module tb_dfs_path_finder_core;

  localparam int  VERTICES       = 16;
  localparam bit  OP_LOAD        = 1'b0;
  localparam bit  OP_SEARCH      = 1'b1;
  localparam int  WATCHDOG_LIMIT = 6000;
  localparam int  HOLD_CYCLES    = 1500;
  localparam int  HOLD_AFTER     = 200;
  localparam int  DRAIN_CYCLES   = 500;

  typedef struct packed {
    logic        op;
    logic [3:0]  row;
    logic [15:0] edges;
    logic [3:0]  start_v;
    logic [3:0]  end_v;
  } path_req_t;

  typedef struct packed {
    logic [3:0] vertex;
    logic       last;
    logic       no_path;
  } path_step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  path_req_t   pending_reqs[$];
  path_step_t  expected_path[$];
  logic [15:0] graph_rows[VERTICES];
  path_req_t   cur_req;
  int          req_count = 0;
  int          fail_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_cycle = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          stall_cycles = 0;

  dfs_path_finder_core #(.VERTICES(VERTICES)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void queue_step(input logic [3:0] vertex, input logic last,
                                     input logic no_path);
    path_step_t s;
    s.vertex  = vertex;
    s.last    = last;
    s.no_path = no_path;
    expected_path.insert(expected_path.size(), s);
  endfunction

  function automatic void predict_path(input path_req_t r);
    logic [VERTICES-1:0] seen;
    logic [3:0]          via[VERTICES];
    logic [3:0]          stk_v[VERTICES];
    logic [4:0]          stk_j[VERTICES];
    logic [3:0]          trail[VERTICES];
    logic [3:0]          u;
    logic [3:0]          v;
    int                  depth;
    int                  top;
    int                  j;
    int                  cnt;
    bit                  pushed;
    if (r.op == OP_LOAD) begin
      graph_rows[r.row] = r.edges;
      return;
    end
    if (r.start_v == r.end_v) begin
      queue_step(r.start_v, 1'b1, 1'b0);
      return;
    end
    seen = '0;
    seen[r.start_v] = 1'b1;
    via[r.start_v] = r.start_v;
    stk_v[0] = r.start_v;
    stk_j[0] = '0;
    depth = 1;
    while (depth > 0) begin
      top = depth - 1;
      u = stk_v[top];
      j = int'(stk_j[top]);
      pushed = 1'b0;
      while (j < VERTICES && !pushed) begin
        if (graph_rows[u][j] && !seen[j]) begin
          stk_j[top] = 5'(j + 1);
          via[j] = u;
          seen[j] = 1'b1;
          if (depth < VERTICES) begin
            stk_v[depth] = 4'(j);
            stk_j[depth] = '0;
            depth++;
          end
          pushed = 1'b1;
        end else begin
          j++;
        end
      end
      if (!pushed) depth--;
    end
    if (!seen[r.end_v]) begin
      queue_step(4'd0, 1'b1, 1'b1);
      return;
    end
    cnt = 0;
    v = r.end_v;
    while (v != r.start_v && cnt < VERTICES) begin
      trail[cnt] = v;
      cnt++;
      v = via[v];
    end
    if (v != r.start_v || cnt >= VERTICES) begin
      queue_step(4'd0, 1'b1, 1'b1);
      return;
    end
    trail[cnt] = r.start_v;
    cnt++;
    for (int k = 0; k < cnt; k++)
      queue_step(trail[cnt-1-k], k == cnt - 1, 1'b0);
  endfunction

  function automatic logic [15:0] rand_edges();
    logic [15:0] e;
    case ($urandom_range(0, 3))
      0: e = 16'($urandom & $urandom & $urandom);
      1: e = 16'($urandom);
      2: e = 16'($urandom | $urandom);
      default: e = (16'd1 << $urandom_range(0, 15)) | (16'd1 << $urandom_range(0, 15));
    endcase
    return e;
  endfunction

  task automatic add_req(input logic op, input logic [3:0] row, input logic [15:0] edges,
                         input logic [3:0] start_v, input logic [3:0] end_v);
    path_req_t r;
    r = '{op, row, edges, start_v, end_v};
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_path(cur_req);
        req_count <= req_count + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          s_tdata <= {4'b0, cur_req.end_v, cur_req.start_v, cur_req.edges, cur_req.row};
          s_tuser <= cur_req.op;
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= int'($urandom_range(1, 20));
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (!hold_done && req_count >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        case ((rx_cycle / 300) % 4)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= rx_cycle[0];
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    path_step_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_path.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: vertex=%0d last=%0b no_path=%0b",
                   m_tdata[3:0], m_tlast, m_tuser);
      end else begin
        want = expected_path.pop_front();
        if (m_tdata[3:0] !== want.vertex || m_tlast !== want.last || m_tuser !== want.no_path)
        begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected vertex=%0d last=%0b no_path=%0b, got %0d %0b %0b",
                     want.vertex, want.last, want.no_path, m_tdata[3:0], m_tlast, m_tuser);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[dfs_path_finder_core] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [3:0] sv;
    // chain graph 0 -> 1 -> ... -> 15, with self loops at both ends
    for (int i = 0; i < VERTICES; i++)
      add_req(OP_LOAD, 4'(i), (i == 0) ? 16'h0003 : (i == 15) ? 16'h8000 : (16'd1 << (i + 1)),
              4'($urandom), 4'($urandom));
    add_req(OP_SEARCH, 4'($urandom), 16'($urandom), 4'd0, 4'd15);
    add_req(OP_SEARCH, 4'($urandom), 16'($urandom), 4'd5, 4'd5);
    add_req(OP_SEARCH, 4'($urandom), 16'($urandom), 4'd0, 4'd0);
    add_req(OP_SEARCH, 4'($urandom), 16'($urandom), 4'd15, 4'd0);
    add_req(OP_LOAD, 4'd0, 16'hFFFF, 4'($urandom), 4'($urandom));
    add_req(OP_SEARCH, 4'($urandom), 16'($urandom), 4'd0, 4'd15);
    add_req(OP_LOAD, 4'd7, 16'h0000, 4'($urandom), 4'($urandom));
    add_req(OP_SEARCH, 4'($urandom), 16'($urandom), 4'd0, 4'd15);
    add_req(OP_SEARCH, 4'($urandom), 16'($urandom), 4'd15, 4'd15);
    for (int n = 0; n < 405; n++) begin
      if ($urandom_range(0, 9) < 4) begin
        add_req(OP_LOAD, 4'($urandom), rand_edges(), 4'($urandom), 4'($urandom));
      end else begin
        sv = 4'($urandom);
        add_req(OP_SEARCH, 4'($urandom), 16'($urandom), sv,
                ($urandom_range(0, 9) == 0) ? sv : 4'($urandom));
      end
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() > 0 || s_tvalid || expected_path.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_path.size() == 0)
      $display("[dfs_path_finder_core] OK");
    else
      $display("[dfs_path_finder_core] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dfs_pf_pkg.sv
rtl/core/dfs_path_finder_core.sv
tb/sv/tb_dfs_path_finder_core.sv
